### hw/rtl/range_distinct_count_window_top_defines.svh
// Assertion macros shared by the range distinct count window RTL.
`ifndef RANGE_DISTINCT_COUNT_WINDOW_TOP_DEFINES_SVH
`define RANGE_DISTINCT_COUNT_WINDOW_TOP_DEFINES_SVH

`ifndef SYNTH

// Check that cond holds at every clock edge outside reset.
`define RDCW_ASSERT_ALW(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("rdcw: invariant violated");

// Check that cons holds in the same cycle as ante.
`define RDCW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rdcw: same-cycle implication violated");

// Check that cons holds in the cycle after ante.
`define RDCW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rdcw: next-cycle implication violated");

`else

`define RDCW_ASSERT_ALW(lbl, cond)
`define RDCW_ASSERT_IMP(lbl, ante, cons)
`define RDCW_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### hw/rtl/rdcw_pkg.sv
// Types, constants and codes of the range distinct count window block.
package rdcw_pkg;

  // Sizing; both values must be powers of two.
  localparam int MAX_LENGTH  = 1024;
  localparam int VALUE_RANGE = 1024;

  localparam int ADDR_W = $clog2(MAX_LENGTH);
  localparam int VAL_W  = $clog2(VALUE_RANGE);
  localparam int CNT_W  = $clog2(MAX_LENGTH + 1);

  // Field widths of the beats.
  localparam int CMD_W  = 1;
  localparam int POS_W  = 11;
  localparam int EVAL_W = 10;
  localparam int TAG_W  = 16;
  localparam int DCNT_W = 11;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [POS_W-1:0]  position;
    logic [EVAL_W-1:0] element_value;
    logic [POS_W-1:0]  range_left;
    logic [POS_W-1:0]  range_right;
    logic [TAG_W-1:0]  query_tag;
  } in_item_t;

  typedef struct packed {
    logic [DCNT_W-1:0] distinct_count;
    logic [TAG_W-1:0]  result_tag;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_PICK,
    ST_FETCH,
    ST_UPDATE,
    ST_LD_FETCH_OLD,
    ST_LD_UPD_OLD,
    ST_LD_FETCH_NEW,
    ST_LD_UPD_NEW,
    ST_LD_WR,
    ST_REPLY
  } rdcw_state_t;

  // Source of the value whose histogram entry is fetched.
  typedef enum logic [1:0] {
    FS_NONE,
    FS_STORE,
    FS_LOAD
  } fetch_src_t;

  // Histogram update applied to the fetched entry.
  typedef enum logic [1:0] {
    HOP_NONE,
    HOP_ENTER,
    HOP_LEAVE,
    HOP_MOVE
  } hist_op_t;

  typedef struct packed {
    logic       clr_step;
    logic       accept;
    logic       pick;
    fetch_src_t fetch;
    hist_op_t   hop;
    logic       store_wr;
    logic       out_load;
  } rdcw_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic item_bad;
    logic in_window;
    logic move_pending;
    logic out_free;
  } rdcw_sts_t;

endpackage

### hw/rtl/rdcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rdcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/rdcw_ctrl.sv
// Sequencer of the range distinct count window block.
`include "range_distinct_count_window_top_defines.svh"

module rdcw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rdcw_pkg::rdcw_sts_t sts,
  output rdcw_pkg::rdcw_cmd_t cmd
);
  import rdcw_pkg::*;

  rdcw_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.fetch    = FS_NONE;
    cmd.hop      = HOP_NONE;
    in_stall     = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts.is_query) begin
          state_nxt = sts.item_bad ? ST_REPLY : ST_PICK;
        end else if (sts.item_bad) begin
          state_nxt = ST_IDLE;
        end else if (sts.in_window) begin
          state_nxt = ST_LD_FETCH_OLD;
        end else begin
          state_nxt = ST_LD_WR;
        end
      end
      ST_PICK: begin
        if (sts.move_pending) begin
          cmd.pick  = 1'b1;
          state_nxt = ST_FETCH;
        end else begin
          state_nxt = ST_REPLY;
        end
      end
      ST_FETCH: begin
        cmd.fetch = FS_STORE;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.hop   = HOP_MOVE;
        state_nxt = ST_PICK;
      end
      ST_LD_FETCH_OLD: begin
        cmd.fetch = FS_STORE;
        state_nxt = ST_LD_UPD_OLD;
      end
      ST_LD_UPD_OLD: begin
        cmd.hop   = HOP_LEAVE;
        state_nxt = ST_LD_FETCH_NEW;
      end
      ST_LD_FETCH_NEW: begin
        cmd.fetch = FS_LOAD;
        state_nxt = ST_LD_UPD_NEW;
      end
      ST_LD_UPD_NEW: begin
        cmd.hop   = HOP_ENTER;
        state_nxt = ST_LD_WR;
      end
      ST_LD_WR: begin
        cmd.store_wr = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_REPLY: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The clearing pass runs once after reset and never again.
  `RDCW_ASSERT_NXT(a_clear_once, state_r != ST_CLEAR, state_r != ST_CLEAR)
  // A result only lands in a free output register.
  `RDCW_ASSERT_IMP(a_load_free, cmd.out_load, sts.out_free && state_r == ST_REPLY)
  // Beats are taken only while idle.
  `RDCW_ASSERT_IMP(a_take_idle, !in_stall, state_r == ST_IDLE)

endmodule

### hw/rtl/rdcw_dp.sv
// Datapath: element store, histogram, window ends, distinct count, result register.
`include "range_distinct_count_window_top_defines.svh"

module rdcw_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  rdcw_pkg::in_item_t  in_data,
  input  logic                out_stall,
  output logic                out_valid,
  output rdcw_pkg::out_item_t out_data,
  input  rdcw_pkg::rdcw_cmd_t cmd,
  output rdcw_pkg::rdcw_sts_t sts
);
  import rdcw_pkg::*;

  localparam logic [POS_W-1:0] MAX_POS  = POS_W'(MAX_LENGTH);
  localparam logic [VAL_W-1:0] LAST_VAL = VAL_W'(VALUE_RANGE - 1);

  in_item_t          item_r;
  logic [POS_W-1:0]  wl_r, wl_nxt;
  logic [POS_W-1:0]  wr_r, wr_nxt;
  logic [CNT_W-1:0]  dist_r, dist_nxt;
  logic [VAL_W-1:0]  clr_addr_r;
  logic [VAL_W-1:0]  v_r;
  logic              dir_enter_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [VAL_W-1:0]  ld_val;
  logic [ADDR_W-1:0] ld_addr;
  logic              ld_bad, q_bad;

  logic              mv_wl_dec, mv_wr_inc, mv_wl_inc, mv_wr_dec;
  logic [POS_W-1:0]  mv_pos;
  logic              mv_enter;

  logic              st_we;
  logic [ADDR_W-1:0] st_raddr;
  logic [VAL_W-1:0]  st_rdata;

  logic              h_we;
  logic [VAL_W-1:0]  h_waddr, h_raddr;
  logic [CNT_W-1:0]  h_wdata, h_rdata, h_new;
  logic              upd_enter;

  // Item decode.
  assign ld_val  = item_r.element_value[VAL_W-1:0];
  assign ld_addr = ADDR_W'(item_r.position - POS_W'(1));
  assign ld_bad  = (item_r.position == '0) || (item_r.position > MAX_POS);
  assign q_bad   = (item_r.range_left == '0) || (item_r.range_right > MAX_POS) ||
                   (item_r.range_left > item_r.range_right);

  // Next window step: widen first, then narrow.
  always_comb begin
    mv_wl_dec = wl_r > item_r.range_left;
    mv_wr_inc = wr_r < item_r.range_right;
    mv_wl_inc = wl_r < item_r.range_left;
    mv_wr_dec = wr_r > item_r.range_right;
    wl_nxt    = wl_r;
    wr_nxt    = wr_r;
    mv_pos    = wr_r;
    mv_enter  = 1'b0;
    if (mv_wl_dec) begin
      mv_pos   = wl_r - POS_W'(1);
      wl_nxt   = mv_pos;
      mv_enter = 1'b1;
    end else if (mv_wr_inc) begin
      mv_pos   = wr_r + POS_W'(1);
      wr_nxt   = mv_pos;
      mv_enter = 1'b1;
    end else if (mv_wl_inc) begin
      mv_pos = wl_r;
      wl_nxt = wl_r + POS_W'(1);
    end else if (mv_wr_dec) begin
      mv_pos = wr_r;
      wr_nxt = wr_r - POS_W'(1);
    end
  end

  // Element store.
  assign st_we    = cmd.store_wr;
  assign st_raddr = cmd.pick ? ADDR_W'(mv_pos - POS_W'(1)) : ld_addr;

  rdcw_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_LENGTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (ld_addr),
    .wdata (ld_val),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Histogram read-modify-write.
  assign h_raddr   = (cmd.fetch == FS_LOAD) ? ld_val : st_rdata;
  assign upd_enter = (cmd.hop == HOP_ENTER) || ((cmd.hop == HOP_MOVE) && dir_enter_r);

  always_comb begin
    dist_nxt = dist_r;
    h_new    = h_rdata;
    if (cmd.hop != HOP_NONE) begin
      if (upd_enter) begin
        h_new = h_rdata + CNT_W'(1);
        if (h_rdata == '0) begin
          dist_nxt = dist_r + CNT_W'(1);
        end
      end else if (h_rdata != '0) begin
        h_new = h_rdata - CNT_W'(1);
        if (h_rdata == CNT_W'(1)) begin
          dist_nxt = dist_r - CNT_W'(1);
        end
      end
    end
  end

  assign h_we    = cmd.clr_step || (cmd.hop != HOP_NONE);
  assign h_waddr = cmd.clr_step ? clr_addr_r : v_r;
  assign h_wdata = cmd.clr_step ? '0 : h_new;

  rdcw_ram #(
    .WIDTH (CNT_W),
    .DEPTH (VALUE_RANGE)
  ) u_hist (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r        <= POS_W'(1);
      wr_r        <= '0;
      dist_r      <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.pick) begin
        wl_r <= wl_nxt;
        wr_r <= wr_nxt;
      end
      dist_r <= dist_nxt;
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + VAL_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_data;
    end
    if (cmd.pick) begin
      dir_enter_r <= mv_enter;
    end
    if (cmd.fetch != FS_NONE) begin
      v_r <= h_raddr;
    end
    if (cmd.out_load) begin
      out_data_r.distinct_count <= q_bad ? '0 : DCNT_W'(dist_r);
      out_data_r.result_tag     <= item_r.query_tag;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.clr_last     = clr_addr_r == LAST_VAL;
  assign sts.is_query     = item_r.command == CMD_QUERY;
  assign sts.item_bad     = (item_r.command == CMD_QUERY) ? q_bad : ld_bad;
  assign sts.in_window    = (item_r.position >= wl_r) && (item_r.position <= wr_r);
  assign sts.move_pending = mv_wl_dec || mv_wr_inc || mv_wl_inc || mv_wr_dec;
  assign sts.out_free     = !out_valid_r || !out_stall;

  // The window is never more than one position past empty.
  `RDCW_ASSERT_ALW(a_win_order, (POS_W+1)'(wl_r) <= (POS_W+1)'(wr_r) + (POS_W+1)'(1))
  // A good query is answered only once the window sits exactly on its range.
  `RDCW_ASSERT_IMP(a_win_match, cmd.out_load && !q_bad,
                   wl_r == item_r.range_left && wr_r == item_r.range_right)
  // A stalled result holds its valid and its payload.
  `RDCW_ASSERT_NXT(a_out_hold, out_valid_r && out_stall, out_valid_r && $stable(out_data_r))

endmodule

### hw/rtl/range_distinct_count_window_top.sv
// Top level of the range distinct count window block.
// Load beats (command 0) write one value into a 1-based element store;
// query beats (command 1) return the number of distinct values between
// range_left and range_right, inclusive, tagged with query_tag. The block
// keeps a window over the store with an occurrence histogram and a running
// distinct count, and moves the window ends one position at a time: first
// widening, then narrowing. Each position moved takes a store read, then a
// histogram read-modify-write through a RAM with registered read data. A
// query holds the block while both window ends travel to its range, and its
// result is loaded into the output register once that register is free; a
// query with a bad range leaves the window where it is and answers 0. A load
// inside the current window also updates the histogram (the old value leaves
// the histogram and the new one enters); a load to position 0 or past the
// store is dropped.
// One beat is worked on at a time. After reset the histogram is cleared
// entry by entry, during which in_stall stays high. The result sits in
// an output register, so the next beat is taken while a result still waits
// on out_stall. Presenting queries in block order keeps the window travel short.
module range_distinct_count_window_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rdcw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rdcw_pkg::out_item_t out_data
);
  import rdcw_pkg::*;

  rdcw_cmd_t cmd;
  rdcw_sts_t sts;

  // Sequencer: clearing pass, decode, window walk, load update, result hand-off.
  rdcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage, window ends, distinct count and the output register.
  rdcw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the range distinct count window block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rdcw_pkg::*;

  // Generous bound on the whole run, including the histogram clear after reset.
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  // Margin for a load accepted last that may still be in flight.
  localparam int unsigned TAIL_CYCLES  = 24;
  localparam int unsigned MAX_REPORTS  = 100;
  localparam int unsigned RANDOM_BEATS = 520;
  localparam int unsigned FILL_END     = 40;
  // Written prefix that the long sweeps run over.
  localparam int unsigned SWEEP_END    = 256;
  localparam int unsigned POS_TOP      = (1 << POS_W) - 1;

  // Patterns the result side uses to stall.
  typedef enum int unsigned {
    STALL_NONE,
    STALL_COIN,
    STALL_THREE_OF_FOUR,
    STALL_LONG
  } stall_mode_e;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  range_distinct_count_window_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Shadow of the block: element store, per-value occurrence counts,
  // window ends and the running distinct count.
  // ---------------------------------------------------------------------
  logic [EVAL_W-1:0] stored_value [1:MAX_LENGTH];
  bit                is_written   [1:MAX_LENGTH];
  int unsigned       value_hits   [VALUE_RANGE];
  int unsigned       win_lo       = 1;
  int unsigned       win_hi       = 0;
  int unsigned       distinct_now = 0;
  // Every position from 1 up to this one has been written. Valid queries
  // stay at or below it, so the window never sweeps over an unwritten entry.
  int unsigned       written_upto = 0;

  out_item_t   expected_counts [$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;

  function automatic void count_in(input logic [EVAL_W-1:0] v);
    if (value_hits[v] == 0) distinct_now++;
    value_hits[v]++;
  endfunction

  function automatic void count_out(input logic [EVAL_W-1:0] v);
    if (value_hits[v] != 0) begin
      value_hits[v]--;
      if (value_hits[v] == 0) distinct_now--;
    end
  endfunction

  // Apply one accepted beat to the shadow; queue the answer of a query.
  function automatic void track_beat(input in_item_t beat);
    int unsigned       pos;
    int unsigned       lo;
    int unsigned       hi;
    logic [EVAL_W-1:0] v;
    out_item_t         answer;
    if (beat.command == CMD_LOAD) begin
      pos = beat.position;
      v   = EVAL_W'(beat.element_value % VALUE_RANGE);
      // Drop loads to position zero or past the store.
      if (pos >= 1 && pos <= MAX_LENGTH) begin
        // A load inside the window swaps one occurrence for another.
        if (pos >= win_lo && pos <= win_hi) begin
          count_out(stored_value[pos]);
          count_in(v);
        end
        stored_value[pos] = v;
        is_written[pos]   = 1'b1;
        while (written_upto < MAX_LENGTH && is_written[written_upto + 1])
          written_upto++;
      end
    end else begin
      lo = beat.range_left;
      hi = beat.range_right;
      answer.result_tag = beat.query_tag;
      if (lo < 1 || hi > MAX_LENGTH || lo > hi) begin
        // Bad range: hold the window, answer zero.
        answer.distinct_count = '0;
      end else begin
        // Widen first, then narrow, so no count drops below zero.
        while (win_lo > lo) begin
          win_lo--;
          count_in(stored_value[win_lo]);
        end
        while (win_hi < hi) begin
          win_hi++;
          count_in(stored_value[win_hi]);
        end
        while (win_lo < lo) begin
          count_out(stored_value[win_lo]);
          win_lo++;
        end
        while (win_hi > hi) begin
          count_out(stored_value[win_hi]);
          win_hi--;
        end
        answer.distinct_count = DCNT_W'(distinct_now);
      end
      expected_counts.push_back(answer);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Beat builders; fields a command does not use carry random bits.
  // ---------------------------------------------------------------------
  function automatic in_item_t load_beat(input int unsigned pos, input int unsigned val);
    in_item_t beat;
    beat.command       = CMD_LOAD;
    beat.position      = POS_W'(pos);
    beat.element_value = EVAL_W'(val);
    beat.range_left    = POS_W'($urandom);
    beat.range_right   = POS_W'($urandom);
    beat.query_tag     = TAG_W'($urandom);
    return beat;
  endfunction

  function automatic in_item_t query_beat(input int unsigned lo, input int unsigned hi,
                                          input int unsigned tag);
    in_item_t beat;
    beat.command       = CMD_QUERY;
    beat.position      = POS_W'($urandom);
    beat.element_value = EVAL_W'($urandom);
    beat.range_left    = POS_W'(lo);
    beat.range_right   = POS_W'(hi);
    beat.query_tag     = TAG_W'(tag);
    return beat;
  endfunction

  // Mostly a small alphabet so values repeat and counts stay interesting.
  function automatic int unsigned pick_value();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 15);
    return $urandom_range(0, VALUE_RANGE - 1);
  endfunction

  // ---------------------------------------------------------------------
  // Sender: bursts of random length with random gaps; some bursts are long
  // and gap-free. Hold the payload until the beat is taken.
  // ---------------------------------------------------------------------
  task automatic send_beat(input in_item_t beat);
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(16, 48);
      end else begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 12);
      end
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    track_beat(beat);
  endtask

  // Drop valid and wait until every queued answer has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_counts.size() != 0);
    burst_left = 0;
  endtask

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Receiver: switch at random between stall patterns.
  // ---------------------------------------------------------------------
  stall_mode_e stall_mode = STALL_NONE;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;

  always @(posedge clk) begin
    stall_tick++;
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(40, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:          out_stall <= 1'b0;
      STALL_COIN:          out_stall <= ($urandom_range(0, 1) == 0);
      STALL_THREE_OF_FOUR: out_stall <= (stall_tick % 4 != 0);
      default:             out_stall <= (stall_tick % 11 < 8);
    endcase
  end

  // Compare each taken result with the oldest queued answer.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("result with no query waiting: count %0d tag %0d",
                                  out_data.distinct_count, out_data.result_tag));
      end else begin
        want = expected_counts.pop_front();
        if (out_data.distinct_count !== want.distinct_count)
          report_mismatch($sformatf("tag %0d: distinct_count %0d, want %0d",
                                    want.result_tag, out_data.distinct_count,
                                    want.distinct_count));
        if (out_data.result_tag !== want.result_tag)
          report_mismatch($sformatf("result_tag %0d, want %0d",
                                    out_data.result_tag, want.result_tag));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Field extremes, dropped loads, bad ranges and loads inside the window.
  task automatic test_directed();
    send_beat(load_beat(1, 0));
    send_beat(load_beat(2, VALUE_RANGE - 1));
    send_beat(load_beat(3, 0));
    send_beat(load_beat(4, 512));
    send_beat(load_beat(5, VALUE_RANGE - 1));
    send_beat(load_beat(6, 'h155));
    send_beat(load_beat(7, 'h2AA));
    send_beat(load_beat(8, 5));
    // Drop these: position zero, just past the store, all position bits set.
    send_beat(load_beat(0, 77));
    send_beat(load_beat(MAX_LENGTH + 1, 78));
    send_beat(load_beat(POS_TOP, 79));
    // First query sweeps the window up from empty.
    send_beat(query_beat(1, 1, 0));
    send_beat(query_beat(1, 8, 16'hFFFF));
    send_beat(query_beat(3, 5, 3));
    send_beat(query_beat(8, 8, 4));
    // Bad ranges: left zero, right past the store, left above right.
    send_beat(query_beat(0, 4, 5));
    send_beat(query_beat(2, MAX_LENGTH + 1, 6));
    send_beat(query_beat(6, 5, 7));
    send_beat(query_beat(POS_TOP, POS_TOP, 8));
    // Loads inside the window: one value leaves, a repeated one joins.
    send_beat(query_beat(2, 7, 9));
    send_beat(load_beat(4, VALUE_RANGE - 1));
    send_beat(query_beat(2, 7, 10));
    send_beat(load_beat(6, 'h2AA));
    send_beat(query_beat(1, 8, 11));
    wait_for_results();
  endtask

  // Grow the written prefix so random windows have room to move.
  task automatic test_fill_prefix();
    while (written_upto < FILL_END) send_beat(load_beat(written_upto + 1, pick_value()));
  endtask

  // Mostly well-formed queries that drift, jump or cover the whole prefix,
  // mixed with loads (extending, inside the prefix, anywhere, dropped) and a
  // few bad ranges.
  task automatic test_random();
    int unsigned last_lo = 1;
    int unsigned lo;
    int unsigned hi;
    int unsigned pos;
    int unsigned sel;
    int          drift;
    for (int unsigned n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 160 == 159) wait_for_results();
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        sel = $urandom_range(0, 99);
        if (sel < 35 && written_upto < MAX_LENGTH) pos = written_upto + 1;
        else if (sel < 70) pos = $urandom_range(1, written_upto);
        else if (sel < 85) pos = $urandom_range(1, MAX_LENGTH);
        else if (sel < 93) pos = 0;
        else pos = $urandom_range(MAX_LENGTH + 1, POS_TOP);
        send_beat(load_beat(pos, pick_value()));
      end else if (sel < 36) begin
        sel = $urandom_range(0, 2);
        if (sel == 0) begin
          lo = 0;
          hi = $urandom_range(0, POS_TOP);
        end else if (sel == 1) begin
          lo = $urandom_range(1, MAX_LENGTH);
          hi = $urandom_range(MAX_LENGTH + 1, POS_TOP);
        end else begin
          hi = $urandom_range(1, MAX_LENGTH - 1);
          lo = $urandom_range(hi + 1, POS_TOP);
        end
        send_beat(query_beat(lo, hi, $urandom_range(0, 65535)));
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          drift = int'(last_lo) + int'($urandom_range(0, 12)) - 6;
          if (drift < 1) drift = 1;
          if (drift > int'(written_upto)) drift = written_upto;
          lo = drift;
          hi = lo + $urandom_range(0, (written_upto - lo < 24) ? written_upto - lo : 24);
        end else if (sel < 85) begin
          lo = $urandom_range(1, written_upto);
          hi = $urandom_range(lo, written_upto);
        end else if (sel < 92) begin
          lo = $urandom_range(1, written_upto);
          hi = lo;
        end else begin
          lo = 1;
          hi = written_upto;
        end
        last_lo = lo;
        send_beat(query_beat(lo, hi, $urandom_range(0, 65535)));
      end
    end
    wait_for_results();
  endtask

  // Fill a longer prefix, then long sweeps and a load at the last position.
  task automatic test_long_sweep();
    for (int unsigned p = 1; p <= SWEEP_END; p++)
      if (!is_written[p]) send_beat(load_beat(p, pick_value()));
    send_beat(query_beat(1, SWEEP_END, $urandom_range(0, 65535)));
    send_beat(query_beat(SWEEP_END, SWEEP_END, $urandom_range(0, 65535)));
    send_beat(query_beat(1, 1, $urandom_range(0, 65535)));
    send_beat(query_beat(SWEEP_END / 2, SWEEP_END, $urandom_range(0, 65535)));
    send_beat(load_beat(SWEEP_END - 24, VALUE_RANGE - 1));
    send_beat(load_beat(MAX_LENGTH, pick_value()));
    send_beat(query_beat(1, SWEEP_END, $urandom_range(0, 65535)));
    send_beat(query_beat(SWEEP_END - 1, SWEEP_END, $urandom_range(0, 65535)));
  endtask

  initial begin
    // Hold reset, then release it; the block then clears its histogram with
    // in_stall high, which the handshake simply waits out.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_fill_prefix();
    test_random();
    test_long_sweep();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_counts.size() != 0)
      report_mismatch($sformatf("%0d answers never came", expected_counts.size()));
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### range_distinct_count_window_top.f
+incdir+hw/rtl
hw/rtl/rdcw_pkg.sv
hw/rtl/rdcw_ram.sv
hw/rtl/rdcw_ctrl.sv
hw/rtl/rdcw_dp.sv
hw/rtl/range_distinct_count_window_top.sv
tb/sv/tb_top.sv
